// ===== rtl/core/ltc_pkg.sv =====
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int COUNT_W       = $clog2(CACHE_ENTRIES + 1);

    localparam int KIND_W   = 2;
    localparam int PROC_W   = 16;
    localparam int PAGE_W   = 10;
    localparam int FRAME_W  = 10;
    localparam int EVICT_W  = 2;
    localparam int LIMIT_W  = 5;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_LIMIT_ADDR = '0;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = LIMIT_W'(4);

    localparam logic [KIND_W-1:0] KIND_LOOKUP     = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_INSERT     = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_INVALIDATE = KIND_W'(2);

    localparam logic [EVICT_W-1:0] EVICT_NONE  = EVICT_W'(0);
    localparam logic [EVICT_W-1:0] EVICT_QUOTA = EVICT_W'(1);
    localparam logic [EVICT_W-1:0] EVICT_FULL  = EVICT_W'(2);

    typedef struct packed {
        logic               valid;
        logic [PROC_W-1:0]  proc;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ===== rtl/core/lru_translation_cache_per_process_quota.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// request   in         i_valid / o_stall  i_kind, i_process_id, i_page_number, i_frame_in
// result    out        o_valid / i_stall  o_hit, o_frame_out, o_eviction
// config    in         APB (psel..pready) per_process_limit at byte address 0
//
// Each request has a compare step, in which every cell compares its entry,
// and an update step, in which the chain closes the gap and loads the new entry.
// The result register decouples the output; a stalled result holds the update
// step, and no new request is taken until the update of the last one is done.
// Reset is synchronous: the cache empties and the limit returns to four.

module lru_translation_cache_per_process_quota (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ltc_pkg::KIND_W-1:0]     i_kind,
    input  logic [ltc_pkg::PROC_W-1:0]     i_process_id,
    input  logic [ltc_pkg::PAGE_W-1:0]     i_page_number,
    input  logic [ltc_pkg::FRAME_W-1:0]    i_frame_in,

    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_hit,
    output logic [ltc_pkg::FRAME_W-1:0]    o_frame_out,
    output logic [ltc_pkg::EVICT_W-1:0]    o_eviction,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ltc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ltc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ltc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ltc_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [LIMIT_W-1:0]    r_limit;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    n_count;
    logic [KIND_W-1:0]     r_kind;
    logic [PROC_W-1:0]     r_proc;
    logic [PAGE_W-1:0]     r_page;
    logic [FRAME_W-1:0]    r_frame;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [FRAME_W-1:0]    r_out_frame;
    logic [EVICT_W-1:0]    r_out_evict;

    logic                  w_capture;
    logic                  w_exec_go;

    t_entry                w_entry   [CACHE_ENTRIES];
    t_entry                w_next    [CACHE_ENTRIES];
    t_cell_ctl             w_ctl     [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] w_valid;
    logic [CACHE_ENTRIES-1:0] w_pm;
    logic [CACHE_ENTRIES-1:0] w_hm;
    logic [CACHE_ENTRIES-1:0] w_th_hit;
    logic [CACHE_ENTRIES-1:0] w_th_own;
    logic [CACHE_ENTRIES-1:0] w_drop_mask;
    logic [FRAME_W-1:0]    w_hit_frame;
    logic                  w_found;
    logic                  w_have_own;
    logic [COUNT_W-1:0]    w_owned;
    logic [LIMIT_W-1:0]    w_limit_eff;
    logic                  w_full;
    logic                  w_do_drop;
    logic                  w_do_load;
    logic [COUNT_W-1:0]    w_load_idx;
    logic                  w_res_hit;
    logic [FRAME_W-1:0]    w_res_frame;
    logic [EVICT_W-1:0]    w_res_evict;
    t_entry                w_load_entry;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == REG_LIMIT_ADDR) ? APB_DATA_W'(r_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == REG_LIMIT_ADDR)) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_EXEC;
            ST_EXEC: if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall   = 1'b1;
        w_capture = 1'b0;
        w_exec_go = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall   = 1'b0;
                w_capture = i_valid;
            end
            ST_EXEC: begin
                w_exec_go = !r_out_valid || !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_kind  <= i_kind;
            r_proc  <= i_process_id;
            r_page  <= i_page_number;
            r_frame <= i_frame_in;
        end
    end

    // ---------------- cell chain ----------------
    genvar g;
    generate
        for (g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
            if (g == CACHE_ENTRIES - 1) begin : g_last
                assign w_next[g] = '0;
            end else begin : g_mid
                assign w_next[g] = w_entry[g + 1];
            end

            assign w_ctl[g].capture = w_capture;
            assign w_ctl[g].shift   = w_exec_go && w_do_drop && w_drop_mask[g];
            assign w_ctl[g].load    = w_exec_go && w_do_load && (w_load_idx == COUNT_W'(g));
            assign w_valid[g]       = w_entry[g].valid;

            ltc_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl[g]),
                .i_req_proc   (i_process_id),
                .i_req_page   (i_page_number),
                .i_next       (w_next[g]),
                .i_load_entry (w_load_entry),
                .o_entry      (w_entry[g]),
                .o_proc_match (w_pm[g]),
                .o_hit_match  (w_hm[g])
            );
        end
    endgenerate

    // ---------------- update decision ----------------
    // Thermometer masks mark every slot at or above the first match; those
    // slots take their upper neighbor's entry when the gap closes.
    always_comb begin
        w_hit_frame = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            w_th_hit[i] = |(CACHE_ENTRIES'(w_hm << (CACHE_ENTRIES - 1 - i)));
            w_th_own[i] = |(CACHE_ENTRIES'(w_pm << (CACHE_ENTRIES - 1 - i)));
            if (w_hm[i]) begin
                w_hit_frame = w_hit_frame | w_entry[i].frame;
            end
        end
    end

    assign w_found     = |w_hm;
    assign w_have_own  = |w_pm;
    assign w_owned     = COUNT_W'($countones(w_pm));
    assign w_limit_eff = (r_limit == '0) ? LIMIT_W'(1) : r_limit;
    assign w_full      = (r_count == COUNT_W'(CACHE_ENTRIES));

    always_comb begin
        w_do_drop   = 1'b0;
        w_do_load   = 1'b0;
        w_drop_mask = w_th_hit;
        w_res_hit   = 1'b0;
        w_res_frame = '0;
        w_res_evict = EVICT_NONE;
        n_count     = r_count;
        unique case (r_kind)
            KIND_LOOKUP: begin
                w_res_hit   = w_found;
                w_res_frame = w_found ? w_hit_frame : '0;
                w_do_drop   = w_found;
                w_do_load   = w_found;
            end
            KIND_INSERT: begin
                w_res_hit   = w_found;
                w_res_frame = w_found ? w_hit_frame : '0;
                w_do_load   = 1'b1;
                if (w_found) begin
                    w_do_drop = 1'b1;
                end else if (w_have_own && (int'(w_owned) >= int'(w_limit_eff))) begin
                    w_do_drop   = 1'b1;
                    w_drop_mask = w_th_own;
                    w_res_evict = EVICT_QUOTA;
                end else if (w_full) begin
                    w_do_drop   = 1'b1;
                    w_drop_mask = '1;
                    w_res_evict = EVICT_FULL;
                end else begin
                    n_count = r_count + COUNT_W'(1);
                end
            end
            KIND_INVALIDATE: begin
                w_res_hit   = w_found;
                w_res_frame = w_found ? w_hit_frame : '0;
                w_do_drop   = w_found;
                if (w_found) begin
                    n_count = r_count - COUNT_W'(1);
                end
            end
            default: begin
                w_res_hit = 1'b0;
            end
        endcase
    end

    // After a removal the most recent slot is count-1, otherwise count.
    assign w_load_idx = w_do_drop ? (r_count - COUNT_W'(1)) : r_count;

    assign w_load_entry.valid = 1'b1;
    assign w_load_entry.proc  = r_proc;
    assign w_load_entry.page  = r_page;
    assign w_load_entry.frame = (r_kind == KIND_LOOKUP) ? w_hit_frame : r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_exec_go) begin
            r_count <= n_count;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_go) begin
            r_out_hit   <= w_res_hit;
            r_out_frame <= w_res_frame;
            r_out_evict <= w_res_evict;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_frame_out = r_out_frame;
    assign o_eviction  = r_out_evict;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CACHE_ENTRIES))
        else $error("entry count exceeds cache size");

    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("cell valid bits disagree with entry count");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $onehot0(w_hm))
        else $error("more than one cell matched the same process and page");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_EXEC))
        else $error("result appeared without an update cycle");
`endif

endmodule

// ===== rtl/core/ltc_cell.sv =====
`timescale 1ns / 1ps

module ltc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ltc_pkg::t_cell_ctl         i_ctl,
    input  logic [ltc_pkg::PROC_W-1:0] i_req_proc,
    input  logic [ltc_pkg::PAGE_W-1:0] i_req_page,
    input  ltc_pkg::t_entry            i_next,
    input  ltc_pkg::t_entry            i_load_entry,
    output ltc_pkg::t_entry            o_entry,
    output logic                       o_proc_match,
    output logic                       o_hit_match
);
    import ltc_pkg::*;

    logic               r_valid;
    logic [PROC_W-1:0]  r_proc;
    logic [PAGE_W-1:0]  r_page;
    logic [FRAME_W-1:0] r_frame;
    logic               r_proc_match;
    logic               r_hit_match;
    logic               w_proc_eq;

    assign w_proc_eq = r_valid && (r_proc == i_req_proc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_ctl.shift) begin
            r_valid <= i_next.valid;
        end
    end

    // A load overrides the shift so the appended entry lands on top of the
    // slot that the closing gap would otherwise fill.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_proc  <= i_load_entry.proc;
            r_page  <= i_load_entry.page;
            r_frame <= i_load_entry.frame;
        end else if (i_ctl.shift) begin
            r_proc  <= i_next.proc;
            r_page  <= i_next.page;
            r_frame <= i_next.frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_proc_match <= w_proc_eq;
            r_hit_match  <= w_proc_eq && (r_page == i_req_page);
        end
    end

    assign o_entry      = '{valid: r_valid, proc: r_proc, page: r_page, frame: r_frame};
    assign o_proc_match = r_proc_match;
    assign o_hit_match  = r_hit_match;

endmodule
